### hdl/arc_pkg.sv
package arc_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [31:0] col_t;

  localparam int unsigned NumCols = 4;
  localparam logic [7:0] GfPoly = 8'h1B;

  typedef enum logic {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } reg_idx_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
  };

  function automatic byte_t gf_dbl(byte_t a);
    return {a[6:0], 1'b0} ^ (a[7] ? GfPoly : 8'h00);
  endfunction

endpackage

### hdl/arc_col_lane.sv
// One column: key add, S-box, MixColumns. Inputs already row-shifted.
module arc_col_lane (
  input  arc_pkg::col_t state,
  input  arc_pkg::col_t key,
  output arc_pkg::col_t result
);

  arc_pkg::byte_t s0, s1, s2, s3;
  arc_pkg::byte_t d0, d1, d2, d3;
  arc_pkg::col_t  x;

  assign x  = state ^ key;
  assign s0 = arc_pkg::SBOX[x[31:24]];
  assign s1 = arc_pkg::SBOX[x[23:16]];
  assign s2 = arc_pkg::SBOX[x[15:8]];
  assign s3 = arc_pkg::SBOX[x[7:0]];
  assign d0 = arc_pkg::gf_dbl(s0);
  assign d1 = arc_pkg::gf_dbl(s1);
  assign d2 = arc_pkg::gf_dbl(s2);
  assign d3 = arc_pkg::gf_dbl(s3);

  assign result = {d0 ^ d1 ^ s1 ^ s2 ^ s3,
                   s0 ^ d1 ^ d2 ^ s2 ^ s3,
                   s0 ^ s1 ^ d2 ^ d3 ^ s3,
                   d0 ^ s0 ^ s1 ^ s2 ^ d3};

endmodule

### hdl/aes_round_core.sv
// aes_round_core: one AES round without the closing key addition.
// Input beat: block_high/block_low (row-major state, byte 0 at the top)
// on in_valid/in_stall. Output beat: result_high/result_low on
// out_valid/out_stall. The key is written through cfg_we/cfg_index/
// cfg_data (0 = key_high, 1 = key_low). The user must write it only
// while the block is idle; the block itself does not enforce this.
// Four column lanes do key add, S-box and MixColumns in parallel; the
// row shift is wiring in front of them and the lanes' columns are
// merged back into rows in the output register.
// Throughput: one beat per cycle; the single output register refills in
// the cycle it is taken, so input is stalled only while the output is
// held and stalled.
// Reset clears the key and the output valid.
module aes_round_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] block_high,
  input  logic [63:0] block_low,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] result_high,
  output logic [63:0] result_low
);

  logic [127:0] key_reg;
  logic [127:0] st;
  logic [127:0] res_next;
  arc_pkg::col_t lane_in [arc_pkg::NumCols];
  arc_pkg::col_t lane_key [arc_pkg::NumCols];
  arc_pkg::col_t lane_out [arc_pkg::NumCols];

  assign st = {block_high, block_low};
  assign in_stall = out_valid & out_stall;

  // byte i sits at bits 127-8i
  for (genvar c = 0; c < 4; c++) begin : g_lane
    localparam int C1 = (c + 1) % 4;
    localparam int C2 = (c + 2) % 4;
    localparam int C3 = (c + 3) % 4;
    assign lane_in[c] = {st[127 - 8*c -: 8], st[127 - 8*(4 + C1) -: 8],
                         st[127 - 8*(8 + C2) -: 8], st[127 - 8*(12 + C3) -: 8]};
    assign lane_key[c] = {key_reg[127 - 8*c -: 8], key_reg[127 - 8*(4 + C1) -: 8],
                          key_reg[127 - 8*(8 + C2) -: 8], key_reg[127 - 8*(12 + C3) -: 8]};
    arc_col_lane u_lane (
      .state  (lane_in[c]),
      .key    (lane_key[c]),
      .result (lane_out[c])
    );
    assign res_next[127 - 8*c -: 8]        = lane_out[c][31:24];
    assign res_next[127 - 8*(4 + c) -: 8]  = lane_out[c][23:16];
    assign res_next[127 - 8*(8 + c) -: 8]  = lane_out[c][15:8];
    assign res_next[127 - 8*(12 + c) -: 8] = lane_out[c][7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_reg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        arc_pkg::REG_KEY_HIGH: key_reg[127:64] <= cfg_data;
        arc_pkg::REG_KEY_LOW:  key_reg[63:0]   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      {result_high, result_low} <= res_next;
    end
  end

endmodule

### verif/aes_round_core_tb.sv
module aes_round_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandBeats = 1480;
  localparam int StallLimit = 5000;

  class round_scoreboard;
    logic [63:0] key_hi, key_lo;
    logic [127:0] pending[$];
    int errors;

    function new();
      key_hi = '0;
      key_lo = '0;
      errors = 0;
    endfunction

    function logic [7:0] xtime(logic [7:0] a);
      logic [7:0] v;
      v = {a[6:0], 1'b0};
      if (a[7]) v = v ^ 8'h1B;
      return v;
    endfunction

    function logic [127:0] round_out(logic [63:0] bh, logic [63:0] bl);
      logic [7:0] st[16], sh[16], mc[16];
      logic [127:0] blk, key, res;
      logic [7:0] a0, a1, a2, a3;
      blk = {bh, bl};
      key = {key_hi, key_lo};
      for (int i = 0; i < 16; i++)
        st[i] = arc_pkg::SBOX[blk[127 - 8*i -: 8] ^ key[127 - 8*i -: 8]];
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++) sh[r*4 + c] = st[r*4 + ((c + r) % 4)];
      for (int c = 0; c < 4; c++) begin
        a0 = sh[c]; a1 = sh[4 + c]; a2 = sh[8 + c]; a3 = sh[12 + c];
        mc[c]      = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
        mc[4 + c]  = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
        mc[8 + c]  = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
        mc[12 + c] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
      for (int i = 0; i < 16; i++) res[127 - 8*i -: 8] = mc[i];
      return res;
    endfunction

    function void note_block(logic [63:0] bh, logic [63:0] bl);
      pending.push_back(round_out(bh, bl));
    endfunction

    function void check_result(logic [63:0] rh, logic [63:0] rl);
      logic [127:0] e;
      if (pending.size() == 0) begin
        $error("unexpected result %h %h", rh, rl);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (rh !== e[127:64]) begin
        $error("result_high: expected %h, got %h", e[127:64], rh);
        errors++;
      end
      if (rl !== e[63:0]) begin
        $error("result_low: expected %h, got %h", e[63:0], rl);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic cfg_index = 0;
  logic [63:0] cfg_data = '0;
  logic in_valid = 0, in_stall;
  logic [63:0] block_high = '0, block_low = '0;
  logic out_valid, out_stall = 0;
  logic [63:0] result_high, result_low;
  bit calm = 0;
  int quiet = 0;
  round_scoreboard sb = new();

  aes_round_core dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(result_high, result_low);
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > StallLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(negedge clk) out_stall <= !calm && !rst && ($urandom_range(99) < 27);

  task automatic write_reg(arc_pkg::reg_idx_t idx, logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    if (idx == arc_pkg::REG_KEY_HIGH) sb.key_hi = val;
    else sb.key_lo = val;
  endtask

  task automatic send_beat(logic [63:0] bh, logic [63:0] bl);
    while (!calm && $urandom_range(99) < 27) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    block_high <= bh;
    block_low <= bl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_block(bh, bl);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  function automatic logic [63:0] rnd64();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return {8{8'($urandom)}};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin
    logic [63:0] keys[4];
    keys = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h2B7E_1516_28AE_D2A6, 64'hABF7_1588_09CF_4F3C};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    send_beat('0, '0);
    send_beat('1, '1);
    send_beat(64'h3243_F6A8_885A_308D, 64'h3132_9888_0737_0734);
    drain();
    write_reg(arc_pkg::REG_KEY_HIGH, keys[2]);
    write_reg(arc_pkg::REG_KEY_LOW, keys[3]);
    send_beat(64'h3243_F6A8_885A_308D, 64'h3132_9888_0737_0734);
    send_beat(keys[2], keys[3]);
    for (int i = 0; i < 64; i++) send_beat(64'h1 << i, ~(64'h1 << i));
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      if (ph < 4) begin
        write_reg(arc_pkg::REG_KEY_HIGH, keys[ph]);
        write_reg(arc_pkg::REG_KEY_LOW, keys[3 - ph]);
      end else begin
        write_reg(arc_pkg::REG_KEY_HIGH, rnd64());
        write_reg(arc_pkg::REG_KEY_LOW, rnd64());
      end
      calm = (ph == 2);
      for (int i = 0; i < RandBeats / 6; i++) send_beat(rnd64(), rnd64());
      calm = 0;
      drain();
    end
    repeat (5) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

### sim.f
hdl/arc_pkg.sv
hdl/arc_col_lane.sv
hdl/aes_round_core.sv
verif/aes_round_core_tb.sv
